### rtl/top_k_selector_core_defines.svh
// assertion macros shared by the top k selector rtl
`ifndef TOP_K_SELECTOR_CORE_DEFINES_SVH
`define TOP_K_SELECTOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TKS_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TKS_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/tks_pkg.sv
package tks_pkg;

    // fixed port widths
    localparam int SAMPLE_W    = 64;
    localparam int INDEX_W     = 12;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int KEEP_W      = 5;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_KEEP_COUNT     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PICK_LARGEST   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COMPARE_SIGNED = 2'd2;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic load;            // a sample transaction is accepted
        logic shift;           // a result transaction is taken
        logic pick_largest;
        logic compare_signed;
        logic in_range;        // cell position is below the keep count
    } t_cell_ctl;

endpackage

### rtl/tks_cell.sv
module tks_cell
    import tks_pkg::*;
#(
    parameter int VW = 64,
    parameter int PW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic [VW-1:0] i_sample,
    input  logic [PW-1:0] i_pos,
    input  logic          i_seen,
    output logic          o_seen,
    input  logic          i_left_valid,
    input  logic [VW-1:0] i_left_value,
    input  logic [PW-1:0] i_left_pos,
    input  logic          i_right_valid,
    input  logic [VW-1:0] i_right_value,
    input  logic [PW-1:0] i_right_pos,
    output logic          o_valid,
    output logic [VW-1:0] o_value,
    output logic [PW-1:0] o_pos,
    output logic          o_next_valid
);

    logic          r_valid, n_valid;
    logic [VW-1:0] r_value, n_value;
    logic [PW-1:0] r_pos,   n_pos;
    logic [VW-1:0] w_a, w_b;
    logic          w_beaten, w_stop, w_active;

    // rank compare: sample strictly better than the held value
    always_comb begin
        w_a = i_sample;
        w_b = r_value;
        if (i_ctl.compare_signed) begin
            w_a[VW-1] = ~w_a[VW-1];
            w_b[VW-1] = ~w_b[VW-1];
        end
        w_active = r_valid & i_ctl.in_range;
        w_beaten = w_active & (i_ctl.pick_largest ? (w_a > w_b) : (w_a < w_b));
        w_stop   = ~w_active | w_beaten;
    end

    // first stopping cell takes the sample, the ones after it shift down
    assign o_seen = i_seen | w_stop;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_pos   = r_pos;
        if (i_ctl.load) begin
            if (!i_ctl.in_range) begin
                n_valid = 1'b0;
            end else if (i_seen) begin
                n_valid = i_left_valid;
                n_value = i_left_value;
                n_pos   = i_left_pos;
            end else if (w_stop) begin
                n_valid = 1'b1;
                n_value = i_sample;
                n_pos   = i_pos;
            end
        end else if (i_ctl.shift) begin
            n_valid = i_right_valid;
            n_value = i_right_value;
            n_pos   = i_right_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
        r_pos   <= n_pos;
    end

    assign o_valid      = r_valid;
    assign o_value      = r_value;
    assign o_pos        = r_pos;
    assign o_next_valid = n_valid;

endmodule

### rtl/top_k_selector_core.sv
// Streaming stable top-k selector. Samples of one slice arrive in index order, one per
// transaction, and a row of MAX_K insertion cells keeps the k best values (largest or
// smallest, signed or unsigned) with their positions, ties going to the lower position.
// Each cell compares the new sample against its own entry in the same cycle, so one
// sample is taken every clock while a slice is being collected. The transaction with
// tlast set ends the slice: the row then shifts its entries out best first, one result
// per output transaction, and the input side stalls until the last result (tlast) has
// been taken. Results carry a fault flag in tuser when the slice was shorter than k or
// ran past MAX_SLICE_LEN samples (those positions saturate at MAX_SLICE_LEN-1). Keep
// count 0 acts as 1 and counts above MAX_K act as MAX_K; the user must write
// configuration only between slices, as the block itself does not enforce it.
`include "top_k_selector_core_defines.svh"

module top_k_selector_core
    import tks_pkg::*;
#(
    parameter int MAX_K         = 16,
    parameter int MAX_SLICE_LEN = 4096,
    parameter int VALUE_WIDTH   = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [63:0] sample_value
    input  logic                   s_axis_tlast,   // slice_end
    // master stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [63:0] out_value, [75:64] out_index
    output logic                   m_axis_tlast,   // out_last
    output logic                   m_axis_tuser,   // slice_fault
    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int PW     = $clog2(MAX_SLICE_LEN);
    localparam int KEFF_W = ($clog2(MAX_K + 1) > KEEP_W) ? $clog2(MAX_K + 1) : KEEP_W;
    localparam logic [PW-1:0]     LAST_POS = PW'(MAX_SLICE_LEN - 1);
    localparam logic [KEFF_W-1:0] KMAX     = KEFF_W'(MAX_K);

    // configuration registers
    logic [KEEP_W-1:0] r_keep;
    logic              r_largest;
    logic              r_signed;

    // slice control
    logic              r_emit;
    logic              r_fault;
    logic [PW-1:0]     r_cnt;
    logic              r_full;
    logic              r_ovf;

    logic              w_in_acc, w_out_acc, w_short;
    logic [PW-1:0]     w_pos;
    logic [KEFF_W-1:0] w_keep_ext, w_keff;
    logic [MAX_K-1:0]  w_in_range, w_next_valid;

    logic              w_valid [0:MAX_K];
    logic [VALUE_WIDTH-1:0] w_value [0:MAX_K];
    logic [PW-1:0]     w_cpos  [0:MAX_K];
    logic              w_seen  [0:MAX_K];

    assign s_axis_tready = ~r_emit;
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_out_acc     = m_axis_tvalid & m_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep    <= KEEP_W'(1);
            r_largest <= 1'b1;
            r_signed  <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_KEEP_COUNT:     r_keep    <= i_cfg_wdata[KEEP_W-1:0];
                CFG_PICK_LARGEST:   r_largest <= i_cfg_wdata[0];
                CFG_COMPARE_SIGNED: r_signed  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // effective keep count and per-cell range mask
    always_comb begin
        w_keep_ext = KEFF_W'(r_keep);
        if (w_keep_ext == '0) begin
            w_keff = KEFF_W'(1);
        end else if (w_keep_ext > KMAX) begin
            w_keff = KMAX;
        end else begin
            w_keff = w_keep_ext;
        end
        for (int i = 0; i < MAX_K; i++) begin
            w_in_range[i] = KEFF_W'(i) < w_keff;
        end
    end

    // position of the incoming sample, saturating at the last index
    assign w_pos = r_full ? LAST_POS : r_cnt;

    // a range cell that ends up empty means the slice was short
    assign w_short = |(w_in_range & ~w_next_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
            r_cnt  <= '0;
            r_full <= 1'b0;
            r_ovf  <= 1'b0;
        end else if (w_in_acc) begin
            if (s_axis_tlast) begin
                r_emit <= 1'b1;
                r_cnt  <= '0;
                r_full <= 1'b0;
                r_ovf  <= 1'b0;
            end else begin
                if (r_full) begin
                    r_ovf <= 1'b1;
                end else if (r_cnt == LAST_POS) begin
                    r_full <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + PW'(1);
                end
            end
        end else if (w_out_acc && m_axis_tlast) begin
            r_emit <= 1'b0;
        end
    end

    // fault flag for the whole slice, taken with its last sample
    always_ff @(posedge i_clk) begin
        if (w_in_acc && s_axis_tlast) begin
            r_fault <= r_ovf | r_full | w_short;
        end
    end

    // insertion cell row
    assign w_valid[MAX_K] = 1'b0;
    assign w_value[MAX_K] = '0;
    assign w_cpos[MAX_K]  = '0;
    assign w_seen[0]      = 1'b0;

    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        t_cell_ctl              w_ctl;
        logic                   w_lvalid;
        logic [VALUE_WIDTH-1:0] w_lvalue;
        logic [PW-1:0]          w_lpos;

        assign w_ctl.load           = w_in_acc;
        assign w_ctl.shift          = w_out_acc;
        assign w_ctl.pick_largest   = r_largest;
        assign w_ctl.compare_signed = r_signed;
        assign w_ctl.in_range       = w_in_range[g];

        if (g == 0) begin : g_head
            assign w_lvalid = 1'b0;
            assign w_lvalue = '0;
            assign w_lpos   = '0;
        end else begin : g_body
            assign w_lvalid = w_valid[g-1];
            assign w_lvalue = w_value[g-1];
            assign w_lpos   = w_cpos[g-1];
        end

        tks_cell #(
            .VW (VALUE_WIDTH),
            .PW (PW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_sample      (s_axis_tdata[VALUE_WIDTH-1:0]),
            .i_pos         (w_pos),
            .i_seen        (w_seen[g]),
            .o_seen        (w_seen[g+1]),
            .i_left_valid  (w_lvalid),
            .i_left_value  (w_lvalue),
            .i_left_pos    (w_lpos),
            .i_right_valid (w_valid[g+1]),
            .i_right_value (w_value[g+1]),
            .i_right_pos   (w_cpos[g+1]),
            .o_valid       (w_valid[g]),
            .o_value       (w_value[g]),
            .o_pos         (w_cpos[g]),
            .o_next_valid  (w_next_valid[g])
        );
    end

    // results come straight from the head cell
    assign m_axis_tvalid = r_emit;
    assign m_axis_tdata  = {{(OUT_TDATA_W - SAMPLE_W - INDEX_W){1'b0}},
                            INDEX_W'(w_cpos[0]), SAMPLE_W'(w_value[0])};
    assign m_axis_tlast  = ~w_valid[1];
    assign m_axis_tuser  = r_fault;

    // checks
    `TKS_ASSERT_IMP(a_head_valid_in_emit, r_emit, w_valid[0],
        "emitting with an empty head cell")
    `TKS_ASSERT_NXT(a_end_starts_emit, w_in_acc && s_axis_tlast, r_emit && r_cnt == '0,
        "slice end did not start emission")
    `TKS_ASSERT_NXT(a_last_ends_emit, w_out_acc && m_axis_tlast, !r_emit && !w_valid[0],
        "row not empty after last result")

endmodule

### dv/top_k_selector_core_tb.sv
module top_k_selector_core_tb;
    import tks_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD   = 12;
    localparam int          MAX_KEEP     = 16;
    localparam int          SLICE_SPAN   = 4096;
    localparam int          RAND_ITEMS   = 240;
    localparam int          QUIET_AFTER  = 195;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int          PRINT_CAP    = 60;

    // register index with no register behind it
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_NEG  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // one emitted entry of a slice
    typedef struct packed {
        logic [63:0]        value;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               fault;
    } t_hit;

    typedef enum logic [0:0] {ROW_SAMPLE, ROW_CFG} t_row_kind;

    // one line of the directed plan
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_ADDR_W-1:0] reg_sel;
        logic [63:0]           data;
        logic                  tail;
        logic                  typed;
        t_hit                  want;
    } t_row;

    typedef enum logic [1:0] {PAT_WIDE, PAT_TIES, PAT_EDGES, PAT_MIXED} t_pattern;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [SAMPLE_W-1:0]    s_axis_tdata   = '0;
    logic                   s_axis_tlast   = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;
    logic                   i_cfg_wr_en    = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata    = '0;

    // ranking state mirrored from the block
    bit [63:0]        kept_val [MAX_KEEP];
    bit [INDEX_W-1:0] kept_pos [MAX_KEEP];
    int               kept_n   = 0;
    int               seen_n   = 0;
    bit               overran  = 1'b0;
    bit [4:0]         cfg_keep    = 5'd1;
    bit               cfg_largest = 1'b1;
    bit               cfg_signed  = 1'b1;

    t_hit awaited_hits [$];
    t_row plan [$];
    bit   typed_armed = 1'b0;
    t_hit typed_want;

    int err_count    = 0;
    int sample_count = 0;
    int slice_count  = 0;
    int hit_count    = 0;
    bit quiet        = 1'b0;
    bit calm         = 1'b0;
    int stall_left   = 0;

    top_k_selector_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [63:0] sample_value
        .s_axis_tlast  (s_axis_tlast),   // slice_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [63:0] out_value, [75:64] out_index
        .m_axis_tlast  (m_axis_tlast),   // out_last
        .m_axis_tuser  (m_axis_tuser),   // slice_fault
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2.0) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Regression FAIL");
        $finish;
    end

    // strict rank order under the current mode
    function automatic bit beats(bit [63:0] a, bit [63:0] b);
        if (a == b) return 1'b0;
        if (cfg_signed)
            return cfg_largest ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
        return cfg_largest ? (a > b) : (a < b);
    endfunction

    // insert one sample and, at slice end, queue the entries best first
    function automatic void rank_sample(bit [63:0] v, bit tail, bit post);
        int k;
        int pos;
        int slot;
        int i;
        bit fault;
        k = (cfg_keep == 0) ? 1 : (cfg_keep > MAX_KEEP) ? MAX_KEEP : int'(cfg_keep);
        if (seen_n >= SLICE_SPAN) begin
            pos = SLICE_SPAN - 1;
            overran = 1'b1;
        end else begin
            pos = seen_n;
            seen_n++;
        end
        if (kept_n > k) kept_n = k;
        slot = 0;
        while (slot < kept_n && !beats(v, kept_val[slot])) slot++;
        if (slot < k) begin
            i = (kept_n < k) ? kept_n : k - 1;
            while (i > slot) begin
                kept_val[i] = kept_val[i-1];
                kept_pos[i] = kept_pos[i-1];
                i--;
            end
            kept_val[slot] = v;
            kept_pos[slot] = pos[INDEX_W-1:0];
            if (kept_n < k) kept_n++;
        end
        if (!tail) return;
        fault = overran || (kept_n < k);
        if (post) begin
            for (i = 0; i < kept_n; i++)
                awaited_hits.push_back('{kept_val[i], kept_pos[i], i == kept_n - 1, fault});
        end
        for (i = 0; i < MAX_KEEP; i++) begin
            kept_val[i] = '0;
            kept_pos[i] = '0;
        end
        kept_n  = 0;
        seen_n  = 0;
        overran = 1'b0;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    // both handshakes are settled by the falling edge before the clock that takes them
    always @(negedge i_clk) begin : watch
        t_hit want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                rank_sample(s_axis_tdata, s_axis_tlast, !typed_armed);
                if (typed_armed) begin
                    awaited_hits.push_back(typed_want);
                    typed_armed = 1'b0;
                end
                sample_count++;
                if (s_axis_tlast) slice_count++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                hit_count++;
                if (awaited_hits.size() == 0) begin
                    report_mismatch("result with nothing pending", m_axis_tdata[63:0], '0);
                end else begin
                    want = awaited_hits.pop_front();
                    if (m_axis_tdata[63:0] !== want.value)
                        report_mismatch("out_value", m_axis_tdata[63:0], want.value);
                    if (m_axis_tdata[75:64] !== want.index)
                        report_mismatch("out_index", 64'(m_axis_tdata[75:64]), 64'(want.index));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("out_last", 64'(m_axis_tlast), 64'(want.last));
                    if (m_axis_tuser !== want.fault)
                        report_mismatch("slice_fault", 64'(m_axis_tuser), 64'(want.fault));
                end
            end
        end
    end

    // result side back pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 1) begin
            stall_left = stall_left - 1;
        end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(1, 17);
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = 0;
        end
    end

    // one sample transaction, maybe after a gap; called and returns at a rising edge
    task automatic send_sample(logic [63:0] v, bit tail);
        if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= tail;
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // drop valid, wait until every pending result has been taken, then idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (awaited_hits.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= sel;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (sel)
            CFG_KEEP_COUNT:     cfg_keep = val;
            CFG_PICK_LARGEST:   cfg_largest = val[0];
            CFG_COMPARE_SIGNED: cfg_signed = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] draw_value(t_pattern pat);
        int s;
        if (pat == PAT_MIXED) pat = t_pattern'($urandom_range(0, 2));
        case (pat)
            PAT_TIES: begin
                s = int'($urandom_range(0, 6)) - 3;
                return 64'(s);
            end
            PAT_EDGES: begin
                case ($urandom_range(0, 5))
                    0: return 64'd0;
                    1: return MAX_POS;
                    2: return MIN_NEG;
                    3: return ALL_ONES;
                    4: return 64'd1;
                    default: return MIN_NEG | 64'd1;
                endcase
            end
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_row sample_row(logic [63:0] v, bit tail);
        return '{ROW_SAMPLE, '0, v, tail, 1'b0, '0};
    endfunction

    // single-sample slice at keep count 1: the sample itself at position 0
    function automatic t_row typed_row(logic [63:0] v);
        return '{ROW_SAMPLE, '0, v, 1'b1, 1'b1, '{v, '0, 1'b1, 1'b0}};
    endfunction

    function automatic t_row cfg_row(logic [CFG_ADDR_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
        return '{ROW_CFG, sel, 64'(val), 1'b0, 1'b0, '0};
    endfunction

    initial begin : stimulus
        t_row       row;
        int         k_eff;
        int         span;
        int         n_slices;
        int         s;
        int         e;
        int         rand_samples;
        logic [4:0] keep_w;
        t_pattern   pat;

        // extremes after reset, keep count 1, signed largest
        plan.push_back(typed_row(MAX_POS));
        plan.push_back(typed_row(MIN_NEG));
        plan.push_back(typed_row(ALL_ONES));
        plan.push_back(typed_row(64'd0));
        // equal values: the lower position wins
        plan.push_back(sample_row(64'd5, 1'b0));
        plan.push_back(sample_row(64'd5, 1'b0));
        plan.push_back(sample_row(ALL_ONES, 1'b1));
        // keep count 0 behaves as 1, spare index has no effect
        plan.push_back(cfg_row(CFG_KEEP_COUNT, 5'd0));
        plan.push_back(cfg_row(CFG_SPARE, 5'h1F));
        plan.push_back(sample_row(64'd3, 1'b0));
        plan.push_back(sample_row(64'd9, 1'b1));
        // unsigned compare puts all ones on top
        plan.push_back(cfg_row(CFG_COMPARE_SIGNED, 5'd0));
        plan.push_back(sample_row(ALL_ONES, 1'b0));
        plan.push_back(sample_row(64'd1, 1'b1));
        // short slice at full keep count, smallest first
        plan.push_back(cfg_row(CFG_KEEP_COUNT, 5'd16));
        plan.push_back(cfg_row(CFG_PICK_LARGEST, 5'd0));
        plan.push_back(sample_row(MIN_NEG, 1'b0));
        plan.push_back(sample_row(MAX_POS, 1'b0));
        plan.push_back(sample_row(64'd0, 1'b0));
        plan.push_back(sample_row(64'd0, 1'b1));
        // keep count above the row saturates, signed smallest
        plan.push_back(cfg_row(CFG_KEEP_COUNT, 5'd31));
        plan.push_back(cfg_row(CFG_COMPARE_SIGNED, 5'd1));
        plan.push_back(sample_row(64'd1, 1'b0));
        plan.push_back(sample_row(ALL_ONES, 1'b0));
        plan.push_back(sample_row(MIN_NEG, 1'b1));
        // more samples than keep count 2, with a tie
        plan.push_back(cfg_row(CFG_KEEP_COUNT, 5'd2));
        plan.push_back(sample_row(64'd10, 1'b0));
        plan.push_back(sample_row(-64'sd3, 1'b0));
        plan.push_back(sample_row(-64'sd3, 1'b0));
        plan.push_back(sample_row(64'd7, 1'b1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (plan[r]) begin
            row = plan[r];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.reg_sel, row.data[CFG_DATA_W-1:0]);
            end else begin
                if (row.typed) begin
                    typed_want  = row.want;
                    typed_armed = 1'b1;
                end
                send_sample(row.data, row.tail);
            end
        end

        // random phases, each with its own register setting
        rand_samples = 0;
        while (rand_samples < RAND_ITEMS) begin
            settle();
            calm = !quiet && ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0: keep_w = 5'd0;
                1: keep_w = 5'd1;
                2: keep_w = 5'd16;
                3: keep_w = 5'($urandom_range(17, 31));
                default: keep_w = 5'($urandom_range(2, 8));
            endcase
            write_reg(CFG_KEEP_COUNT, keep_w);
            write_reg(CFG_PICK_LARGEST, 5'($urandom_range(0, 31)));
            write_reg(CFG_COMPARE_SIGNED, 5'($urandom_range(0, 31)));
            if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 5'($urandom_range(0, 31)));
            k_eff = (keep_w == 0) ? 1 : (keep_w > MAX_KEEP) ? MAX_KEEP : int'(keep_w);
            n_slices = $urandom_range(2, 4);
            for (s = 0; s < n_slices; s++) begin
                case ($urandom_range(0, 3))
                    0: span = (k_eff > 1) ? $urandom_range(1, k_eff - 1) : 1;
                    1: span = k_eff;
                    default: span = $urandom_range(k_eff + 1, k_eff + 10);
                endcase
                pat = t_pattern'($urandom_range(0, 3));
                for (e = 0; e < span; e++) begin
                    send_sample(draw_value(pat), e == span - 1);
                    rand_samples++;
                end
            end
            if (rand_samples >= QUIET_AFTER) quiet = 1'b1;
        end

        // drain with no back pressure
        quiet = 1'b1;
        calm  = 1'b0;
        settle();
        repeat (40) @(posedge i_clk);

        $display("checked %0d results from %0d slices (%0d samples)",
                 hit_count, slice_count, sample_count);
        $display("keep counts 0..31, both orders and compare modes, short and full slices");
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
